### sv/jpmv_pkg.sv
package jpmv_pkg;

  localparam int DefaultMaxFields = 64;

  localparam int ValueW = 16;
  localparam int JumpW  = 6;
  localparam int TotalW = 22;
  localparam int FieldW = ValueW + 2 * JumpW;
  localparam int TotalEntryW = TotalW + 1;

  localparam logic signed [TotalW-1:0] TotalMax = {1'b0, {(TotalW-1){1'b1}}};
  localparam logic signed [TotalW-1:0] TotalMin = {1'b1, {(TotalW-1){1'b0}}};

  typedef struct packed {
    logic load;
    logic fetch_i;
    logic latch_i;
    logic issue;
    logic write_total;
    logic next_i;
    logic out_load;
  } jpmv_cmd_t;

  typedef struct packed {
    logic i_zero;
    logic i_final;
    logic j_final;
  } jpmv_status_t;

endpackage

### sv/jpmv_ram.sv
module jpmv_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/jpmv_ctrl.sv
module jpmv_ctrl import jpmv_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         last_field_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  jpmv_status_t status_i,
  output jpmv_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    ST_LOAD  = 7'b0000001,
    ST_FETCH = 7'b0000010,
    ST_LATCH = 7'b0000100,
    ST_SCAN  = 7'b0001000,
    ST_TAIL  = 7'b0010000,
    ST_WRITE = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_field_i) begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd_o.fetch_i = 1'b1;
        state_d = ST_LATCH;
      end
      ST_LATCH: begin
        cmd_o.latch_i = 1'b1;
        if (status_i.i_zero) begin
          // Field 0 is reachable by definition and keeps its own value.
          cmd_o.write_total = 1'b1;
          if (status_i.i_final) begin
            state_d = ST_DONE;
          end else begin
            cmd_o.next_i = 1'b1;
            state_d = ST_FETCH;
          end
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (status_i.j_final) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.write_total = 1'b1;
        if (status_i.i_final) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.next_i = 1'b1;
          state_d = ST_FETCH;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### sv/jpmv_dpath.sv
module jpmv_dpath import jpmv_pkg::*; #(
  parameter int MaxFields = DefaultMaxFields
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [ValueW-1:0] field_value_i,
  input  logic [JumpW-1:0]         long_jump_i,
  input  logic [JumpW-1:0]         short_jump_i,
  input  logic                     last_field_i,
  input  jpmv_cmd_t                cmd_i,
  output jpmv_status_t             status_o,
  output logic signed [TotalW-1:0] best_total_o
);

  localparam int AddrW  = $clog2(MaxFields);
  localparam int CountW = $clog2(MaxFields + 1);
  localparam int SumW   = AddrW + JumpW + 1;

  logic [CountW-1:0] count_q, n_q;
  logic [AddrW-1:0]  i_q, j_q, jd_q;
  logic              dv_q;
  logic              full;

  logic signed [ValueW-1:0] value_i_q;
  logic signed [TotalW-1:0] best_q, last_total_q, out_q;
  logic                     reach_q;

  logic [FieldW-1:0]      field_wdata, field_rdata;
  logic [AddrW-1:0]       field_raddr;
  logic [TotalEntryW-1:0] total_wdata, total_rdata;

  logic [JumpW-1:0]         rd_long, rd_short;
  logic signed [ValueW-1:0] rd_value;
  logic                     rd_reach;
  logic signed [TotalW-1:0] rd_total;

  logic [SumW-1:0]            i_ext, long_tgt, short_tgt;
  logic                       hit;
  logic signed [TotalW:0]     sum;
  logic signed [TotalW-1:0]   cand;

  assign full        = (count_q == CountW'(MaxFields));
  assign field_wdata = {long_jump_i, short_jump_i, field_value_i};
  assign field_raddr = cmd_i.fetch_i ? i_q : j_q;

  jpmv_ram #(.Width(FieldW), .Depth(MaxFields)) u_field_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && !full),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (field_wdata),
    .raddr_i (field_raddr),
    .rdata_o (field_rdata)
  );

  jpmv_ram #(.Width(TotalEntryW), .Depth(MaxFields)) u_total_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write_total),
    .waddr_i (i_q),
    .wdata_i (total_wdata),
    .raddr_i (j_q),
    .rdata_o (total_rdata)
  );

  assign {rd_long, rd_short, rd_value} = field_rdata;
  assign {rd_reach, rd_total}          = total_rdata;

  // Predecessor test: a jump of zero lands on jd itself, which is below i.
  assign i_ext     = SumW'(i_q);
  assign long_tgt  = SumW'(jd_q) + SumW'(rd_long);
  assign short_tgt = SumW'(jd_q) + SumW'(rd_short);
  assign hit       = dv_q && rd_reach && ((long_tgt == i_ext) || (short_tgt == i_ext));

  assign sum = (TotalW+1)'(value_i_q) + (TotalW+1)'(rd_total);
  always_comb begin
    if (sum[TotalW] != sum[TotalW-1]) begin
      cand = sum[TotalW] ? TotalMin : TotalMax;
    end else begin
      cand = sum[TotalW-1:0];
    end
  end

  always_comb begin
    if (status_o.i_zero) begin
      total_wdata = {1'b1, TotalW'(rd_value)};
    end else begin
      total_wdata = {reach_q, best_q};
    end
  end

  assign status_o.i_zero  = (i_q == '0);
  assign status_o.i_final = ((CountW'(i_q) + CountW'(1)) == n_q);
  assign status_o.j_final = ((j_q + AddrW'(1)) == i_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      jd_q    <= '0;
      dv_q    <= 1'b0;
    end else begin
      dv_q <= cmd_i.issue;
      if (cmd_i.load) begin
        if (last_field_i) begin
          n_q     <= full ? count_q : count_q + CountW'(1);
          count_q <= '0;
          i_q     <= '0;
        end else if (!full) begin
          count_q <= count_q + CountW'(1);
        end
      end
      if (cmd_i.next_i) begin
        i_q <= i_q + AddrW'(1);
      end
      if (cmd_i.latch_i) begin
        j_q <= '0;
      end else if (cmd_i.issue) begin
        jd_q <= j_q;
        j_q  <= j_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_i) begin
      value_i_q <= rd_value;
      best_q    <= '0;
      reach_q   <= 1'b0;
    end else if (hit) begin
      reach_q <= 1'b1;
      if (cand > best_q) begin
        best_q <= cand;
      end
    end
    if (cmd_i.write_total) begin
      last_total_q <= total_wdata[TotalW-1:0];
    end
    if (cmd_i.out_load) begin
      out_q <= last_total_q;
    end
  end

  assign best_total_o = out_q;

endmodule

### sv/jump_path_max_value_core.sv
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    field_value_i, long_jump_i, short_jump_i,
//                                                last_field_i
// out      output     out_valid_o / out_ready_i  best_total_o
//
// Fields load at one transaction per cycle. After the transaction that carries last_field_i,
// the scan over the stored row is paced by the single read port of the total memory: each
// predecessor j of field i is read in a cycle of its own. The input is not ready during
// the scan.
// Reset (rst_ni, asynchronous, active low) empties the row and drops any pending result.
// A result waits in the output register while the next row loads; a new scan does not
// publish its result until that register has been taken.
module jump_path_max_value_core import jpmv_pkg::*; #(
  parameter int MaxFields = DefaultMaxFields
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [ValueW-1:0] field_value_i,
  input  logic [JumpW-1:0]         long_jump_i,
  input  logic [JumpW-1:0]         short_jump_i,
  input  logic                     last_field_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [TotalW-1:0] best_total_o
);

  // Commands from the sequencer and status flags from the datapath.
  jpmv_cmd_t    cmd;
  jpmv_status_t status;

  // The sequencer walks load, per-field fetch, predecessor scan and write-back.
  jpmv_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_field_i (last_field_i),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // The datapath holds the field and total memories, the row counters and the
  // running best total with its reachable flag for the field under work.
  jpmv_dpath #(.MaxFields(MaxFields)) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .field_value_i (field_value_i),
    .long_jump_i   (long_jump_i),
    .short_jump_i  (short_jump_i),
    .last_field_i  (last_field_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .best_total_o  (best_total_o)
  );

endmodule

### bench/jump_path_max_value_core_test.sv
`timescale 1ns / 100ps

module jump_path_max_value_core_test;
  import jpmv_pkg::*;

  // The run ends by force after this many cycles.
  localparam int CycleLimit = 1_000_000;
  // Cycles to keep watching the output after the last expected total. This is a little more
  // than one scan of a full row, which is the longest the block can stay busy.
  localparam int DrainCycles = 2400;
  // Number of random fields to send after the directed rows.
  localparam int RandomFields = 1630;
  // Only the first mismatches are printed. All of them are counted.
  localparam int PrintedMismatches = 40;

  // Scoreboard. It keeps its own copy of the row that is loading. When a field carries the
  // last-field mark, it runs the longest-path scan over the stored fields and queues the
  // total that the block should return.
  class best_total_board;
    int row_value [DefaultMaxFields];
    int row_long  [DefaultMaxFields];
    int row_short [DefaultMaxFields];
    int stored;
    logic signed [TotalW-1:0] expected_totals[$];
    int mismatches;
    int checked;

    function new();
      stored = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    task report(input string msg);
      if (mismatches < PrintedMismatches) begin
        $display("MISMATCH at %0t: %s", $realtime, msg);
      end
      mismatches++;
    endtask

    // Forward scan over the stored row. A field is reachable from an earlier reachable field
    // whose long or short jump lands on it. A jump of zero lands on the field itself and so
    // never counts. A reachable field's total never falls below zero, except for field 0.
    function logic signed [TotalW-1:0] row_best_total();
      int total [DefaultMaxFields];
      logic [DefaultMaxFields-1:0] reach;
      int cand;
      reach = '0;
      foreach (total[k]) total[k] = 0;
      total[0] = row_value[0];
      reach[0] = 1'b1;
      for (int i = 1; i < stored; i++) begin
        for (int j = 0; j < i; j++) begin
          if (reach[j] && ((j + row_long[j] == i) || (j + row_short[j] == i))) begin
            cand = row_value[i] + total[j];
            if (cand > int'(TotalMax)) cand = int'(TotalMax);
            if (cand < int'(TotalMin)) cand = int'(TotalMin);
            if (cand > total[i]) total[i] = cand;
            reach[i] = 1'b1;
          end
        end
      end
      return TotalW'(total[stored-1]);
    endfunction

    // Called for every accepted input transaction. Fields beyond the row capacity are dropped,
    // but the last-field mark still closes the row.
    function void note_field(input logic signed [ValueW-1:0] value,
                             input logic [JumpW-1:0] long_jump,
                             input logic [JumpW-1:0] short_jump,
                             input logic last);
      if (stored < DefaultMaxFields) begin
        row_value[stored] = int'(value);
        row_long[stored]  = int'(long_jump);
        row_short[stored] = int'(short_jump);
        stored++;
      end
      if (last) begin
        expected_totals.push_back(row_best_total());
        stored = 0;
      end
    endfunction

    // Called for every accepted output transaction.
    task check_total(input logic signed [TotalW-1:0] got);
      logic signed [TotalW-1:0] want;
      if (expected_totals.size() == 0) begin
        report($sformatf("best_total %0d arrived with no row pending", got));
      end else begin
        want = expected_totals.pop_front();
        checked++;
        if (got !== want) begin
          report($sformatf("best_total got %0d, expected %0d", got, want));
        end
      end
    endtask

    function int pending();
      return expected_totals.size();
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [ValueW-1:0] field_value_i;
  logic [JumpW-1:0]         long_jump_i;
  logic [JumpW-1:0]         short_jump_i;
  logic                     last_field_i;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [TotalW-1:0] best_total_o;

  best_total_board totals;

  // Idling in percent: how often the sender holds back a field and how often the receiver
  // refuses a result. Both change between phases of the run.
  int sender_idle_pct;
  int receiver_stall_pct;

  int cycles = 0;
  int fields_sent;
  int rows_sent;
  int fields_dropped;

  jump_path_max_value_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .field_value_i (field_value_i),
    .long_jump_i   (long_jump_i),
    .short_jump_i  (short_jump_i),
    .last_field_i  (last_field_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .best_total_o  (best_total_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog. A hang anywhere in the run ends here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d totals outstanding.", cycles,
               totals.pending());
      $display("jump_path_max_value_core_test failed");
      $finish;
    end
  end

  // The receiver decides afresh at every edge whether it takes a result. The decision is
  // applied after the edge, so it never races with the sampling below.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Outputs are sampled at the edge, before any assignment of that edge takes effect. A
  // result is taken when valid and ready are both high.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      totals.check_total(best_total_o);
    end
  end

  // Sends one field. The sender may first stay idle for a random number of cycles. Valid is
  // only lowered at an edge where it is not raised again, so a back-to-back transaction keeps
  // valid high and just changes the payload.
  task send_field(input logic signed [ValueW-1:0] value, input logic [JumpW-1:0] long_jump,
                  input logic [JumpW-1:0] short_jump, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    field_value_i <= value;
    long_jump_i   <= long_jump;
    short_jump_i  <= short_jump;
    last_field_i  <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    totals.note_field(value, long_jump, short_jump, last);
    fields_sent++;
    if (last) rows_sent++;
  endtask

  // Sends a random row of the given length. Most jumps are short so that the scan finds long
  // chains of reachable fields. The rest use the full jump range, which covers every jump bit
  // and jumps that land past the end of the row.
  task send_random_row(input int length);
    logic signed [ValueW-1:0] value;
    logic [JumpW-1:0] long_jump;
    logic [JumpW-1:0] short_jump;
    bit well_formed;
    well_formed = ($urandom_range(99) < 75);
    for (int k = 0; k < length; k++) begin
      if ($urandom_range(1)) begin
        value = ValueW'($urandom());
      end else begin
        value = ValueW'($urandom_range(1200) - 200);
      end
      if (well_formed && $urandom_range(9) != 0) begin
        long_jump  = JumpW'($urandom_range(4, 1));
        short_jump = JumpW'($urandom_range(4, 0));
      end else begin
        long_jump  = JumpW'($urandom());
        short_jump = JumpW'($urandom());
      end
      send_field(value, long_jump, short_jump, k == length - 1);
    end
    if (length > DefaultMaxFields) fields_dropped += length - DefaultMaxFields;
  endtask

  // Four idling phases, each over about a quarter of the random fields: none at all, a
  // sparse sender, a slow receiver, and both at once.
  task set_idling(input int quarter);
    case (quarter)
      0: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
      1: begin
        sender_idle_pct    = 81;
        receiver_stall_pct = 0;
      end
      2: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 81;
      end
      default: begin
        sender_idle_pct    = 30;
        receiver_stall_pct = 30;
      end
    endcase
  endtask

  initial begin
    int random_start;
    int pick;
    int length;

    totals = new();
    fields_sent = 0;
    rows_sent = 0;
    fields_dropped = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    field_value_i = '0;
    long_jump_i   = '0;
    short_jump_i  = '0;
    last_field_i  = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows. Single-field rows return the field's own value, the most negative one
    // included. The others cover full-scale values that add up across jumps, jumps that land
    // past the row, zero jumps, and reachable fields whose sum is negative and so clamps to
    // zero.
    send_field(-16'sd32768, 6'd0, 6'd0, 1'b1);
    send_field(16'sd32767, 6'd63, 6'd63, 1'b1);

    send_field(16'sd32767, 6'd1, 6'd2, 1'b0);
    send_field(16'sd32767, 6'd1, 6'd1, 1'b0);
    send_field(16'sd32767, 6'd63, 6'd0, 1'b1);

    send_field(16'sd500, 6'd63, 6'd62, 1'b0);
    send_field(-16'sd7, 6'd0, 6'd0, 1'b1);

    send_field(16'sd10, 6'd1, 6'd0, 1'b0);
    send_field(-16'sd32768, 6'd0, 6'd1, 1'b0);
    send_field(16'sd5, 6'd0, 6'd0, 1'b1);

    send_field(-16'sd100, 6'd2, 6'd3, 1'b0);
    send_field(16'sd1, 6'd1, 6'd1, 1'b0);
    send_field(-16'sd50, 6'd0, 6'd0, 1'b0);
    send_field(-16'sd20, 6'd0, 6'd0, 1'b1);

    send_field(16'sd0, 6'd1, 6'd1, 1'b0);
    send_field(16'sd0, 6'd42, 6'd21, 1'b0);
    send_field(16'sd0, 6'd1, 6'd1, 1'b0);
    send_field(16'sd32767, 6'd1, 6'd1, 1'b1);

    // Random rows. Most are short; some fill a large part of the row, and a few run past
    // its capacity, so that the last-field mark falls on a dropped field.
    random_start = fields_sent;
    while (fields_sent - random_start < RandomFields) begin
      set_idling((fields_sent - random_start) * 4 / RandomFields);
      pick = $urandom_range(99);
      if (pick < 70) begin
        length = $urandom_range(10, 1);
      end else if (pick < 90) begin
        length = $urandom_range(40, 11);
      end else if (pick < 97) begin
        length = $urandom_range(DefaultMaxFields, 41);
      end else begin
        length = $urandom_range(DefaultMaxFields + 8, DefaultMaxFields + 1);
      end
      send_random_row(length);
    end
    in_valid_i <= 1'b0;

    // Let the receiver take what is left, then keep watching for stray results.
    while (totals.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d fields in %0d rows, %0d of them dropped past the row capacity.",
             fields_sent, rows_sent, fields_dropped);
    $display("Checked %0d totals over four idling phases in %0d cycles; %0d mismatches.",
             totals.checked, cycles, totals.mismatches);
    if (totals.mismatches == 0) begin
      $display("jump_path_max_value_core_test passed");
    end else begin
      $display("jump_path_max_value_core_test failed");
    end
    $finish;
  end

endmodule

### jump_path_max_value_core.f
sv/jpmv_pkg.sv
sv/jpmv_ram.sv
sv/jpmv_ctrl.sv
sv/jpmv_dpath.sv
sv/jump_path_max_value_core.sv
bench/jump_path_max_value_core_test.sv
